// ===== design/pl0_pkg.sv =====
// Package for the PL/0 p-code step engine: widths, opcodes, sub-codes and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package pl0_pkg;
   localparam int StackDepth = 2048;
   localparam int CodeDepth  = 512;
   localparam int MaxLevels  = 3;
   localparam int AW = 11;   // stack address width
   localparam int PW = 9;    // pc width
   localparam int WW = 32;   // word width

   typedef logic [AW-1:0] addr_type;
   typedef logic [WW-1:0] word_type;

   localparam logic [3:0] OP_END = 4'd0;
   localparam logic [3:0] OP_LIT = 4'd1;
   localparam logic [3:0] OP_OPR = 4'd2;
   localparam logic [3:0] OP_LOD = 4'd3;
   localparam logic [3:0] OP_STO = 4'd4;
   localparam logic [3:0] OP_CAL = 4'd5;
   localparam logic [3:0] OP_INC = 4'd6;
   localparam logic [3:0] OP_JMP = 4'd7;
   localparam logic [3:0] OP_JPC = 4'd8;
   localparam logic [3:0] OP_SIO = 4'd9;

   localparam logic [31:0] OPR_RET = 32'd0;
   localparam logic [31:0] OPR_NEG = 32'd1;
   localparam logic [31:0] OPR_ADD = 32'd2;
   localparam logic [31:0] OPR_SUB = 32'd3;
   localparam logic [31:0] OPR_MUL = 32'd4;
   localparam logic [31:0] OPR_DIV = 32'd5;
   localparam logic [31:0] OPR_ODD = 32'd6;
   localparam logic [31:0] OPR_MOD = 32'd7;
   localparam logic [31:0] OPR_EQL = 32'd8;
   localparam logic [31:0] OPR_NEQ = 32'd9;
   localparam logic [31:0] OPR_LSS = 32'd10;
   localparam logic [31:0] OPR_LEQ = 32'd11;
   localparam logic [31:0] OPR_GTR = 32'd12;
   localparam logic [31:0] OPR_GEQ = 32'd13;

   localparam logic [31:0] SIO_OUT = 32'd0;
   localparam logic [31:0] SIO_INP = 32'd1;
   localparam logic [31:0] SIO_HLT = 32'd2;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_HALT  = 2'd1;
   localparam logic [1:0] ST_FAULT = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_CHAIN, S_RD0, S_RD1, S_DIV, S_EXEC, S_WR, S_CLEAR, S_OUT
   } state_type;

   // Memory port bundle from sequencer to stack RAM.
   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
   } mem_req_type;

   // Divider control bundle.
   typedef struct packed {
      logic     start;
      logic     want_mod;
      word_type num;
      word_type den;
   } div_req_type;

   // True when a signed 64-bit value lies in the stack range.
   function automatic logic in_stack(input logic signed [63:0] a);
      in_stack = (a >= 0) && (a < StackDepth);
   endfunction
endpackage

// ===== design/pl0_stack_machine_step.sv =====
// Top level of the PL/0 p-code step engine.
// A request passes through the static-chain walk (LOD, STO and CAL with a nonzero level),
// the operand reads, the divider for DIV and MOD, execute, and writeback (CAL writes
// four frame words) before the response is valid.
// One request at a time: the next request is accepted only after the response is taken.
// Reset (synchronous): sp=0, bp=1, pc=0; a clearing pass then zeroes all 2048 stack words.
`timescale 1ns / 1ps
module pl0_stack_machine_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_mode,
   input  logic [1:0]         req_level,
   input  logic signed [31:0] req_operand,
   input  logic signed [31:0] req_input_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [8:0]         rsp_next_pc,
   output logic [10:0]        rsp_stack_top,
   output logic [10:0]        rsp_frame_base,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_out_valid,
   output logic [1:0]         rsp_status
);
   pl0_pkg::mem_req_type mreq;
   pl0_pkg::word_type    rd_data, div_result;
   pl0_pkg::div_req_type dreq;
   logic                 div_done;

   // Stack memory, divider and the sequencer that drives both.
   pl0_stack_ram u_ram (.clock(clock), .mreq(mreq), .rd_data(rd_data));
   pl0_divider u_div (.clock(clock), .reset(reset), .dreq(dreq), .done(div_done),
      .result(div_result));
   pl0_sequencer u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_level(req_level), .req_operand(req_operand),
      .req_input_value(req_input_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_next_pc(rsp_next_pc),
      .rsp_stack_top(rsp_stack_top), .rsp_frame_base(rsp_frame_base),
      .rsp_out_value(rsp_out_value), .rsp_out_valid(rsp_out_valid),
      .rsp_status(rsp_status),
      .mreq(mreq), .rd_data(rd_data), .dreq(dreq), .div_done(div_done),
      .div_result(div_result)
   );
endmodule

// ===== design/pl0_stack_ram.sv =====
// Data stack memory: one write and one registered read port.
// Depends on pl0_pkg.
`timescale 1ns / 1ps
module pl0_stack_ram (
   input  logic                 clock,
   input  pl0_pkg::mem_req_type mreq,
   output pl0_pkg::word_type    rd_data
);
   pl0_pkg::word_type mem [pl0_pkg::StackDepth];
   pl0_pkg::word_type rd_data_ff;

   // Synchronous write and read.
   always_ff @(posedge clock) begin
      if (mreq.wr_en) mem[mreq.wr_addr] <= mreq.wr_data;
      if (mreq.rd_en) rd_data_ff <= mem[mreq.rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== design/pl0_divider.sv =====
// Iterative signed divider, one quotient bit per cycle; truncating division and
// remainder with the dividend's sign. Depends on pl0_pkg.
`timescale 1ns / 1ps
module pl0_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  pl0_pkg::div_req_type dreq,
   output logic                 done,
   output pl0_pkg::word_type    result
);
   localparam int CW = $clog2(pl0_pkg::WW + 1);
   logic              busy_ff, busy_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   pl0_pkg::word_type quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic              nq_ff, nq_in, nr_ff, nr_in, mod_ff, mod_in;
   logic [pl0_pkg::WW:0] trial;
   pl0_pkg::word_type    mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in; quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
      nq_ff <= nq_in; nr_ff <= nr_in; mod_ff <= mod_in;
   end

   // Restoring shift-subtract step.
   always_comb begin
      busy_in = busy_ff; cnt_in = cnt_ff; quo_in = quo_ff; rem_in = rem_ff;
      den_in = den_ff; nq_in = nq_ff; nr_in = nr_ff; mod_in = mod_ff;
      done = 1'b0;
      trial = '0;
      if (dreq.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dreq.num[pl0_pkg::WW-1] ? -dreq.num : dreq.num;
         den_in  = dreq.den[pl0_pkg::WW-1] ? -dreq.den : dreq.den;
         rem_in  = '0;
         nr_in   = dreq.num[pl0_pkg::WW-1];
         nq_in   = dreq.num[pl0_pkg::WW-1] ^ dreq.den[pl0_pkg::WW-1];
         mod_in  = dreq.want_mod;
      end else if (busy_ff) begin
         if (cnt_ff == CW'(pl0_pkg::WW)) begin
            busy_in = 1'b0;
            done = 1'b1;
         end else begin
            trial = {rem_ff, quo_ff[pl0_pkg::WW-1]} - {1'b0, den_ff};
            if (!trial[pl0_pkg::WW]) begin
               rem_in = trial[pl0_pkg::WW-1:0];
               quo_in = {quo_ff[pl0_pkg::WW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[pl0_pkg::WW-2:0], quo_ff[pl0_pkg::WW-1]};
               quo_in = {quo_ff[pl0_pkg::WW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
      end
      mag = mod_ff ? rem_ff : quo_ff;
      result = (mod_ff ? nr_ff : nq_ff) ? -mag : mag;
   end
endmodule

// ===== design/pl0_sequencer.sv =====
// Instruction sequencer: clears the stack after reset, walks the static chain, reads operands
// from the stack RAM, executes, writes back and builds the response. Depends on pl0_pkg.
`timescale 1ns / 1ps
module pl0_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [3:0]            req_mode,
   input  logic [1:0]            req_level,
   input  logic signed [31:0]    req_operand,
   input  logic signed [31:0]    req_input_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [8:0]            rsp_next_pc,
   output logic [10:0]           rsp_stack_top,
   output logic [10:0]           rsp_frame_base,
   output logic signed [31:0]    rsp_out_value,
   output logic                  rsp_out_valid,
   output logic [1:0]            rsp_status,
   output pl0_pkg::mem_req_type  mreq,
   input  pl0_pkg::word_type     rd_data,
   output pl0_pkg::div_req_type  dreq,
   input  logic                  div_done,
   input  pl0_pkg::word_type     div_result
);
   // Control state.
   pl0_pkg::state_type st_ff, st_in;
   pl0_pkg::addr_type  sp_ff, sp_in, bp_ff, bp_in, clr_ff, clr_in;
   logic [8:0]         pc_ff, pc_in;
   logic               stop_ff, stop_in, rv_ff, rv_in;
   logic [1:0]         lev_ff, lev_in;
   // Latched request and working values.
   logic [3:0]         mode_ff, mode_in;
   logic [31:0]        m_ff, m_in, iv_ff, iv_in;
   logic signed [63:0] fb_ff, fb_in;
   pl0_pkg::word_type  a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic [1:0]         wi_ff, wi_in;
   logic [1:0]         nrd;
   // Response registers.
   logic [8:0]  o_pc_ff, o_pc_in;
   logic [10:0] o_sp_ff, o_sp_in, o_bp_ff, o_bp_in;
   logic [31:0] o_v_ff, o_v_in;
   logic        o_ov_ff, o_ov_in;
   logic [1:0]  o_st_ff, o_st_in;

   logic signed [63:0] s_sp, s_bp, s_pc, s_m, nsp, nbp, npc, wa, ra0, ra1;
   logic        ok, halt, ov, wen;
   pl0_pkg::word_type prod;
   pl0_pkg::word_type wv;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= pl0_pkg::S_CLEAR; sp_ff <= '0; bp_ff <= 11'd1; pc_ff <= '0;
         stop_ff <= 1'b0; rv_ff <= 1'b0; clr_ff <= '0;
      end else begin
         st_ff <= st_in; sp_ff <= sp_in; bp_ff <= bp_in; pc_ff <= pc_in;
         stop_ff <= stop_in; rv_ff <= rv_in; clr_ff <= clr_in;
      end
      lev_ff <= lev_in; mode_ff <= mode_in; m_ff <= m_in; iv_ff <= iv_in;
      fb_ff <= fb_in; a_ff <= a_in; b_ff <= b_in; r_ff <= r_in; wi_ff <= wi_in;
      o_pc_ff <= o_pc_in; o_sp_ff <= o_sp_in; o_bp_ff <= o_bp_in;
      o_v_ff <= o_v_in; o_ov_ff <= o_ov_in; o_st_ff <= o_st_in;
   end

   assign req_stall = (st_ff != pl0_pkg::S_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_next_pc = o_pc_ff; assign rsp_stack_top = o_sp_ff;
   assign rsp_frame_base = o_bp_ff; assign rsp_out_value = o_v_ff;
   assign rsp_out_valid = o_ov_ff; assign rsp_status = o_st_ff;

   // Decode of the new pointers and fault checks, from latched operands.
   always_comb begin
      s_sp = 64'(sp_ff); s_bp = 64'(bp_ff); s_pc = 64'(pc_ff);
      s_m = 64'(signed'(m_ff));
      nsp = s_sp; nbp = s_bp; npc = s_pc + 1; ok = 1'b1; halt = 1'b0; ov = 1'b0;
      wen = 1'b0; wa = '0; wv = '0; ra0 = '0; ra1 = '0; nrd = 2'd0;
      prod = a_ff * b_ff;
      case (mode_ff)
         pl0_pkg::OP_END: if (lev_ff == 2'd0 && m_ff == 32'd0) begin
            halt = 1'b1; npc = s_pc;
         end
         pl0_pkg::OP_LIT: begin nsp = s_sp + 1; wen = 1'b1; wa = nsp; wv = m_ff; end
         pl0_pkg::OP_OPR: begin
            if (m_ff == pl0_pkg::OPR_RET) begin
               nrd = 2'd2; ra0 = s_bp + 3; ra1 = s_bp + 2;
               nsp = s_bp - 1; nbp = 64'(signed'(b_ff)); npc = 64'(signed'(a_ff));
               if (!pl0_pkg::in_stack(ra0) || !pl0_pkg::in_stack(ra1)) ok = 1'b0;
            end else if (m_ff == pl0_pkg::OPR_NEG || m_ff == pl0_pkg::OPR_ODD) begin
               nrd = 2'd1; ra1 = s_sp;
               if (!pl0_pkg::in_stack(ra1)) ok = 1'b0;
               wen = 1'b1; wa = s_sp;
               wv = (m_ff == pl0_pkg::OPR_NEG) ? -b_ff : {31'd0, b_ff[0]};
            end else if (m_ff >= pl0_pkg::OPR_ADD && m_ff <= pl0_pkg::OPR_GEQ) begin
               nrd = 2'd2; ra0 = s_sp - 1; ra1 = s_sp;
               if (!pl0_pkg::in_stack(ra0) || !pl0_pkg::in_stack(ra1)) ok = 1'b0;
               nsp = s_sp - 1; wen = 1'b1; wa = nsp;
               case (m_ff)
                  pl0_pkg::OPR_ADD: wv = a_ff + b_ff;
                  pl0_pkg::OPR_SUB: wv = a_ff - b_ff;
                  pl0_pkg::OPR_MUL: wv = r_ff;
                  pl0_pkg::OPR_DIV, pl0_pkg::OPR_MOD: begin
                     wv = r_ff; if (b_ff == '0) ok = 1'b0;
                  end
                  pl0_pkg::OPR_EQL: wv = {31'd0, a_ff == b_ff};
                  pl0_pkg::OPR_NEQ: wv = {31'd0, a_ff != b_ff};
                  pl0_pkg::OPR_LSS: wv = {31'd0, signed'(a_ff) < signed'(b_ff)};
                  pl0_pkg::OPR_LEQ: wv = {31'd0, signed'(a_ff) <= signed'(b_ff)};
                  pl0_pkg::OPR_GTR: wv = {31'd0, signed'(a_ff) > signed'(b_ff)};
                  default:          wv = {31'd0, signed'(a_ff) >= signed'(b_ff)};
               endcase
            end
         end
         pl0_pkg::OP_LOD: begin
            nrd = 2'd1; ra1 = fb_ff + s_m; nsp = s_sp + 1;
            if (!pl0_pkg::in_stack(ra1)) ok = 1'b0;
            wen = 1'b1; wa = nsp; wv = b_ff;
         end
         pl0_pkg::OP_STO: begin
            nrd = 2'd1; ra1 = s_sp; nsp = s_sp - 1;
            if (!pl0_pkg::in_stack(ra1)) ok = 1'b0;
            wen = 1'b1; wa = fb_ff + s_m; wv = b_ff;
         end
         pl0_pkg::OP_CAL: begin
            nbp = s_sp + 1; npc = s_m; wen = 1'b1;
            wa = s_sp + 64'(wi_ff) + 1;
            case (wi_ff)
               2'd0:    wv = '0;
               2'd1:    wv = 32'(fb_ff);
               2'd2:    wv = 32'(bp_ff);
               default: wv = 32'(pc_ff) + 32'd1;
            endcase
            if (!pl0_pkg::in_stack(s_sp + 4)) ok = 1'b0;
         end
         pl0_pkg::OP_INC: nsp = s_sp + s_m;
         pl0_pkg::OP_JMP: npc = s_m;
         pl0_pkg::OP_JPC: begin
            nrd = 2'd1; ra1 = s_sp; nsp = s_sp - 1;
            if (!pl0_pkg::in_stack(ra1)) ok = 1'b0;
            if (b_ff == '0) npc = s_m;
         end
         pl0_pkg::OP_SIO: begin
            if (m_ff == pl0_pkg::SIO_OUT) begin
               nrd = 2'd1; ra1 = s_sp; nsp = s_sp - 1; ov = 1'b1;
               if (!pl0_pkg::in_stack(ra1)) ok = 1'b0;
            end else if (m_ff == pl0_pkg::SIO_INP) begin
               nsp = s_sp + 1; wen = 1'b1; wa = nsp; wv = iv_ff;
            end else if (m_ff == pl0_pkg::SIO_HLT) begin
               halt = 1'b1; npc = s_pc;
            end
         end
         default: ;
      endcase
      if (!pl0_pkg::in_stack(nsp) || !pl0_pkg::in_stack(nbp)) ok = 1'b0;
      if (!halt && (npc < 0 || npc >= pl0_pkg::CodeDepth)) ok = 1'b0;
      if (wen && !pl0_pkg::in_stack(wa)) ok = 1'b0;
      if (!pl0_pkg::in_stack(fb_ff)) ok = 1'b0;
   end

   // Sequencer.
   always_comb begin
      st_in = st_ff; sp_in = sp_ff; bp_in = bp_ff; pc_in = pc_ff; stop_in = stop_ff;
      rv_in = rv_ff && rsp_stall; clr_in = clr_ff; lev_in = lev_ff;
      mode_in = mode_ff; m_in = m_ff; iv_in = iv_ff; fb_in = fb_ff;
      a_in = a_ff; b_in = b_ff; r_in = r_ff; wi_in = wi_ff;
      o_pc_in = o_pc_ff; o_sp_in = o_sp_ff; o_bp_in = o_bp_ff;
      o_v_in = o_v_ff; o_ov_in = o_ov_ff; o_st_in = o_st_ff;
      mreq = '0; dreq = '0;
      dreq.num = a_ff; dreq.den = b_ff; dreq.want_mod = (m_ff == pl0_pkg::OPR_MOD);
      case (st_ff)
         pl0_pkg::S_CLEAR: begin
            mreq.wr_en = 1'b1; mreq.wr_addr = clr_ff; clr_in = clr_ff + 1'b1;
            if (clr_ff == pl0_pkg::addr_type'(pl0_pkg::StackDepth - 1))
               st_in = pl0_pkg::S_IDLE;
         end
         pl0_pkg::S_IDLE: if (req_valid && !req_stall) begin
            mode_in = req_mode; lev_in = req_level; m_in = req_operand;
            iv_in = req_input_value; fb_in = 64'(bp_ff); wi_in = '0;
            a_in = '0; b_in = '0;
            if (stop_ff) begin
               o_pc_in = pc_ff; o_sp_in = sp_ff; o_bp_in = bp_ff; o_v_in = '0;
               o_ov_in = 1'b0; o_st_in = pl0_pkg::ST_HALT; rv_in = 1'b1;
            end else if ((req_mode == pl0_pkg::OP_LOD || req_mode == pl0_pkg::OP_STO ||
                          req_mode == pl0_pkg::OP_CAL) && req_level != 2'd0) begin
               st_in = pl0_pkg::S_CHAIN;
            end else begin
               st_in = pl0_pkg::S_RD0;
            end
         end
         // One static link per pass: read fb+1, then adopt it.
         pl0_pkg::S_CHAIN: begin
            if (wi_ff == 2'd0) begin
               if (!pl0_pkg::in_stack(fb_ff) || !pl0_pkg::in_stack(fb_ff + 1)) begin
                  fb_in = -64'sd1; st_in = pl0_pkg::S_RD0; // forces a fault
               end else begin
                  mreq.rd_en = 1'b1; mreq.rd_addr = pl0_pkg::addr_type'(fb_ff + 1);
                  wi_in = 2'd1;
               end
            end else begin
               fb_in = 64'(signed'(rd_data)); wi_in = '0; lev_in = lev_ff - 1'b1;
               if (lev_ff == 2'd1) st_in = pl0_pkg::S_RD0;
            end
         end
         // Operand reads: first address (a), then second (b).
         pl0_pkg::S_RD0: begin
            wi_in = '0;
            if (nrd == 2'd2) begin
               mreq.rd_en = pl0_pkg::in_stack(ra0);
               mreq.rd_addr = pl0_pkg::addr_type'(ra0);
            end
            st_in = pl0_pkg::S_RD1;
         end
         pl0_pkg::S_RD1: begin
            if (nrd == 2'd2) a_in = rd_data;
            if (nrd != 2'd0) begin
               mreq.rd_en = pl0_pkg::in_stack(ra1);
               mreq.rd_addr = pl0_pkg::addr_type'(ra1);
            end
            st_in = pl0_pkg::S_DIV;
         end
         pl0_pkg::S_DIV: begin
            if (nrd != 2'd0 && wi_ff == 2'd0) b_in = rd_data;
            wi_in = 2'd1;
            if (wi_ff == 2'd0) begin
               if (mode_ff == pl0_pkg::OP_OPR && (m_ff == pl0_pkg::OPR_DIV ||
                   m_ff == pl0_pkg::OPR_MOD) && rd_data != '0) begin
                  dreq.start = 1'b1; dreq.den = rd_data;
               end else begin
                  st_in = pl0_pkg::S_EXEC; wi_in = '0;
               end
            end else if (div_done) begin
               r_in = div_result; st_in = pl0_pkg::S_EXEC; wi_in = '0;
            end
         end
         pl0_pkg::S_EXEC: begin
            if (m_ff == pl0_pkg::OPR_MUL) r_in = prod;
            st_in = pl0_pkg::S_WR;
         end
         // Writeback (CAL writes four words, one per cycle) and response.
         pl0_pkg::S_WR: begin
            if (!ok) begin
               stop_in = 1'b1; o_pc_in = pc_ff; o_sp_in = sp_ff; o_bp_in = bp_ff;
               o_v_in = '0; o_ov_in = 1'b0; o_st_in = pl0_pkg::ST_FAULT;
               rv_in = 1'b1; st_in = pl0_pkg::S_IDLE;
            end else begin
               mreq.wr_en = wen; mreq.wr_addr = pl0_pkg::addr_type'(wa);
               mreq.wr_data = wv;
               if (mode_ff == pl0_pkg::OP_CAL && wi_ff != 2'd3) begin
                  wi_in = wi_ff + 1'b1;
               end else begin
                  sp_in = pl0_pkg::addr_type'(nsp); bp_in = pl0_pkg::addr_type'(nbp);
                  pc_in = npc[8:0]; stop_in = halt;
                  o_pc_in = npc[8:0]; o_sp_in = nsp[10:0]; o_bp_in = nbp[10:0];
                  o_v_in = ov ? b_ff : '0; o_ov_in = ov;
                  o_st_in = halt ? pl0_pkg::ST_HALT : pl0_pkg::ST_RUN;
                  rv_in = 1'b1; st_in = pl0_pkg::S_IDLE;
               end
            end
         end
         default: st_in = pl0_pkg::S_IDLE;
      endcase
   end
endmodule

// ===== design/pl0_checker.sv =====
// Port-level checker for the PL/0 step engine, bound to the top level.
// Depends on pl0_pkg for status codes.
`timescale 1ns / 1ps
module pl0_checker (
   input logic clock, reset, req_valid, req_stall, rsp_valid, rsp_stall,
   input logic [1:0] rsp_status, input logic rsp_out_valid,
   input logic signed [31:0] rsp_out_value
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken with response pending");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
   a_outv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_value == 0)
      else $error("out value without out valid");
   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_status == pl0_pkg::ST_RUN)
      else $error("output with halt");
endmodule

bind pl0_stack_machine_step pl0_checker u_chk (.*);
